// ===== sv/textured_wall_column_shader_core_macros.svh =====
// Assertion macros for the textured wall column shader core.
// Used by the top level only; expects i_clk and i_rst_n in scope.
`ifndef TEXTURED_WALL_COLUMN_SHADER_CORE_MACROS_SVH
`define TEXTURED_WALL_COLUMN_SHADER_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define TWS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define TWS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/tws_pkg.sv =====
// Package for the textured wall column shader core.
// Holds texture geometry, widths, register indexes and pipeline structs.
`default_nettype none
package tws_pkg;
    localparam int TEX_WIDTH   = 64;
    localparam int TEX_HEIGHT  = 64;
    localparam int STORE_DEPTH = 4096;

    localparam int AW   = $clog2(STORE_DEPTH);
    localparam int TXW  = $clog2(TEX_WIDTH);
    localparam int TYW  = $clog2(TEX_HEIGHT);
    localparam int FW   = 16 + $clog2(TEX_WIDTH + 1);
    localparam int AMW  = TYW + TXW + 1;
    localparam int NUMW = 18;
    localparam int DW   = 17;
    localparam int RW   = DW + 1;
    localparam int PW   = DW + $clog2(TEX_HEIGHT + 1);

    localparam int DIV_SPS    = 2;
    localparam int DIV_STAGES = (TYW + DIV_SPS - 1) / DIV_SPS;

    localparam int PAW = 4;
    localparam logic [1:0] REG_SCREEN_HEIGHT = 2'd0;
    localparam logic [1:0] REG_SKY_RGB       = 2'd1;
    localparam logic [1:0] REG_GROUND_RGB    = 2'd2;

    localparam logic [11:0] SCREEN_HEIGHT_RST = 12'd480;

    typedef enum logic [2:0] {
        REGION_CEIL  = 3'b001,
        REGION_WALL  = 3'b010,
        REGION_FLOOR = 3'b100
    } t_region;

    typedef struct packed {
        logic        mode;
        logic [11:0] screen_column;
        logic [11:0] screen_row;
        logic [11:0] wall_top;
        logic [11:0] wall_bottom;
        logic [15:0] wall_height;
        logic [15:0] hit_fraction;
        logic        hit_side;
        logic        ray_x_positive;
        logic        ray_y_negative;
        logic [11:0] texel_index;
        logic [23:0] texel_value;
    } t_req;

    typedef struct packed {
        logic        wr;
        logic        emit;
        t_region     region;
        logic [11:0] col;
        logic [11:0] row;
        logic [23:0] color;
    } t_ctl;

    typedef struct packed {
        t_ctl           ctl;
        logic [TXW-1:0] tx;
        logic [AW-1:0]  widx;
        logic           nonpos;
        logic           ovf;
    } t_dpay;
endpackage
`default_nettype wire

// ===== sv/tws_front.sv =====
// Front stages: input register, row numerator and region decode, then scaling.
// Depends on tws_pkg.
`default_nettype none
module tws_front
    import tws_pkg::*;
(
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_en,
    input  wire logic          i_vld,
    input  wire t_req          i_req,
    input  wire logic [11:0]   i_screen_height,
    input  wire logic [23:0]   i_sky_rgb,
    input  wire logic [23:0]   i_ground_rgb,
    output logic               o_vld,
    output t_dpay              o_pay,
    output logic [PW-1:0]      o_p,
    output logic [DW-1:0]      o_d
);
    logic                   r_v1, r_v2, r_v3;
    t_req                   r_req;
    t_ctl                   r_ctl2, n_ctl2;
    logic [TXW-1:0]         r_tx2, n_tx2;
    logic [AW-1:0]          r_widx2;
    logic signed [NUMW-1:0] r_num2, n_num2;
    logic [DW-1:0]          r_d2, n_d2, r_d3;
    t_dpay                  r_pay3, n_pay3;
    logic [PW-1:0]          r_p3, n_p3;
    logic [15:0]            h_eff;
    logic [FW-1:0]          prod;
    logic [DW-1:0]          num_u;

    always_comb begin
        h_eff = (r_req.wall_height == 16'd0) ? 16'd1 : r_req.wall_height;
        n_d2  = {h_eff, 1'b0};
        n_num2 = $signed({5'b0, r_req.screen_row, 1'b0})
               - $signed({6'b0, i_screen_height})
               + $signed({2'b0, h_eff});
        prod  = FW'(r_req.hit_fraction) * FW'(TEX_WIDTH);
        n_tx2 = TXW'(prod >> 16);
        if ((!r_req.hit_side && r_req.ray_x_positive) ||
            (r_req.hit_side && r_req.ray_y_negative)) begin
            n_tx2 = TXW'(TEX_WIDTH - 1) - n_tx2;
        end
        n_ctl2.wr   = !r_req.mode;
        n_ctl2.emit = r_req.mode && (r_req.screen_row < i_screen_height);
        n_ctl2.col  = r_req.screen_column;
        n_ctl2.row  = r_req.screen_row;
        if (!r_req.mode) begin
            n_ctl2.region = REGION_WALL;
            n_ctl2.color  = r_req.texel_value;
        end else if (r_req.screen_row < r_req.wall_top) begin
            n_ctl2.region = REGION_CEIL;
            n_ctl2.color  = i_sky_rgb;
        end else if (r_req.screen_row < r_req.wall_bottom) begin
            n_ctl2.region = REGION_WALL;
            n_ctl2.color  = 24'd0;
        end else begin
            n_ctl2.region = REGION_FLOOR;
            n_ctl2.color  = i_ground_rgb;
        end
    end

    always_comb begin
        num_u         = r_num2[DW-1:0];
        n_pay3.ctl    = r_ctl2;
        n_pay3.tx     = r_tx2;
        n_pay3.widx   = r_widx2;
        n_pay3.nonpos = r_num2[NUMW-1] || (r_num2 == '0);
        n_pay3.ovf    = !n_pay3.nonpos && (num_u >= r_d2);
        n_p3          = PW'(num_u) * PW'(TEX_HEIGHT);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_vld;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_req   <= i_req;
            r_ctl2  <= n_ctl2;
            r_tx2   <= n_tx2;
            r_widx2 <= AW'(r_req.texel_index);
            r_num2  <= n_num2;
            r_d2    <= n_d2;
            r_pay3  <= n_pay3;
            r_p3    <= n_p3;
            r_d3    <= r_d2;
        end
    end

    assign o_vld = r_v3;
    assign o_pay = r_pay3;
    assign o_p   = r_p3;
    assign o_d   = r_d3;
endmodule
`default_nettype wire

// ===== sv/tws_div.sv =====
// Pipelined restoring divider for the texel row quotient.
// Depends on tws_pkg.
`default_nettype none
module tws_div
    import tws_pkg::*;
(
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_en,
    input  wire logic          i_vld,
    input  wire t_dpay         i_pay,
    input  wire logic [PW-1:0] i_p,
    input  wire logic [DW-1:0] i_d,
    output logic               o_vld,
    output t_dpay              o_pay,
    output logic [TYW-1:0]     o_q
);
    logic [DIV_STAGES-1:0] r_vld;
    logic [RW-1:0]  r_rem [DIV_STAGES];
    logic [RW-1:0]  n_rem [DIV_STAGES];
    logic [TYW-1:0] r_q   [DIV_STAGES];
    logic [TYW-1:0] n_q   [DIV_STAGES];
    logic [PW-1:0]  r_p   [DIV_STAGES];
    logic [DW-1:0]  r_d   [DIV_STAGES];
    t_dpay          r_pay [DIV_STAGES];
    logic [RW-1:0]  w_rem [DIV_STAGES+1];
    logic [TYW-1:0] w_q   [DIV_STAGES+1];
    logic [PW-1:0]  w_p   [DIV_STAGES+1];
    logic [DW-1:0]  w_d   [DIV_STAGES+1];
    t_dpay          w_pay [DIV_STAGES+1];

    always_comb begin
        w_rem[0] = RW'(i_p >> TYW);
        w_q[0]   = '0;
        w_p[0]   = i_p;
        w_d[0]   = i_d;
        w_pay[0] = i_pay;
        for (int s = 0; s < DIV_STAGES; s++) begin
            w_rem[s+1] = r_rem[s];
            w_q[s+1]   = r_q[s];
            w_p[s+1]   = r_p[s];
            w_d[s+1]   = r_d[s];
            w_pay[s+1] = r_pay[s];
        end
    end

    always_comb begin
        logic [RW-1:0]  rem;
        logic [RW-1:0]  t;
        logic [TYW-1:0] q;
        int             k;
        for (int s = 0; s < DIV_STAGES; s++) begin
            rem = w_rem[s];
            q   = w_q[s];
            for (int j = 0; j < DIV_SPS; j++) begin
                k = s * DIV_SPS + j;
                if (k < TYW) begin
                    t = {rem[RW-2:0], w_p[s][TYW-1-k]};
                    if (t >= RW'(w_d[s])) begin
                        rem          = t - RW'(w_d[s]);
                        q[TYW-1-k]   = 1'b1;
                    end else begin
                        rem = t;
                    end
                end
            end
            n_rem[s] = rem;
            n_q[s]   = q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld[0] <= i_vld;
            for (int s = 1; s < DIV_STAGES; s++) begin
                r_vld[s] <= r_vld[s-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int s = 0; s < DIV_STAGES; s++) begin
                r_rem[s] <= n_rem[s];
                r_q[s]   <= n_q[s];
                r_p[s]   <= w_p[s];
                r_d[s]   <= w_d[s];
                r_pay[s] <= w_pay[s];
            end
        end
    end

    assign o_vld = r_vld[DIV_STAGES-1];
    assign o_pay = w_pay[DIV_STAGES];
    assign o_q   = w_q[DIV_STAGES];
endmodule
`default_nettype wire

// ===== sv/tws_tex.sv =====
// Texel address stage and texture store with registered read.
// Depends on tws_pkg.
`default_nettype none
module tws_tex
    import tws_pkg::*;
(
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_en,
    input  wire logic           i_vld,
    input  wire t_dpay          i_pay,
    input  wire logic [TYW-1:0] i_q,
    output logic                o_vld,
    output logic [11:0]         o_col,
    output logic [11:0]         o_row,
    output logic [23:0]         o_color
);
    logic           r_va, r_vb;
    t_ctl           r_ctla, r_ctlb;
    logic [AW-1:0]  r_addra, n_addra;
    logic [23:0]    r_rd;
    logic [TYW-1:0] ty;
    logic [23:0]    r_mem [STORE_DEPTH];

    always_comb begin
        if (i_pay.nonpos) begin
            ty = '0;
        end else if (i_pay.ovf) begin
            ty = TYW'(TEX_HEIGHT - 1);
        end else begin
            ty = i_q;
        end
        if (i_pay.ctl.wr) begin
            n_addra = i_pay.widx;
        end else begin
            n_addra = AW'(AMW'(ty) * AMW'(TEX_WIDTH) + AMW'(i_pay.tx));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
        end else if (i_en) begin
            r_va <= i_vld;
            r_vb <= r_va;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ctla  <= i_pay.ctl;
            r_addra <= n_addra;
            r_ctlb  <= r_ctla;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en && r_va) begin
            if (r_ctla.wr) begin
                r_mem[r_addra] <= r_ctla.color;
            end else begin
                r_rd <= r_mem[r_addra];
            end
        end
    end

    assign o_vld   = r_vb && r_ctlb.emit;
    assign o_col   = r_ctlb.col;
    assign o_row   = r_ctlb.row;
    assign o_color = (r_ctlb.region == REGION_WALL) ? r_rd : r_ctlb.color;
endmodule
`default_nettype wire

// ===== sv/textured_wall_column_shader_core.sv =====
// Path: an accepted request's pixel reaches o_valid through the input register, two front stages,
// three divider stages, address, store read and output registers. Throughput: one request
// per cycle while o_ready is high; the six-bit row divide is pipelined two bits per stage.
// Texel write requests and off-screen rows produce no output. Reset is synchronous,
// active low; it resets valid bits and config registers, the texture store is not cleared.
// Top level: APB registers, pipeline, output register with skid. Depends on tws_pkg.
`default_nettype none
`include "textured_wall_column_shader_core_macros.svh"
module textured_wall_column_shader_core
    import tws_pkg::*;
(
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            psel,
    input  wire logic            penable,
    input  wire logic            pwrite,
    input  wire logic [PAW-1:0]  paddr,
    input  wire logic [31:0]     pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    input  wire logic            i_valid,
    output logic                 o_ready,
    input  wire logic            i_mode,
    input  wire logic [11:0]     i_screen_column,
    input  wire logic [11:0]     i_screen_row,
    input  wire logic [11:0]     i_wall_top,
    input  wire logic [11:0]     i_wall_bottom,
    input  wire logic [15:0]     i_wall_height,
    input  wire logic [15:0]     i_hit_fraction,
    input  wire logic            i_hit_side,
    input  wire logic            i_ray_x_positive,
    input  wire logic            i_ray_y_negative,
    input  wire logic [11:0]     i_texel_index,
    input  wire logic [23:0]     i_texel_value,
    output logic                 o_valid,
    input  wire logic            i_ready,
    output logic [11:0]          o_pixel_column,
    output logic [11:0]          o_pixel_row,
    output logic [23:0]          o_pixel_color
);
    logic [11:0]    r_screen_height;
    logic [23:0]    r_sky_rgb, r_ground_rgb;
    logic           cfg_wr;
    logic [1:0]     cfg_idx;
    logic           en;
    logic           out_stall;
    t_req           req;
    logic           f_vld, d_vld, t_vld;
    t_dpay          f_pay, d_pay;
    logic [PW-1:0]  f_p;
    logic [DW-1:0]  f_d;
    logic [TYW-1:0] d_q;
    logic [11:0]    t_col, t_row;
    logic [23:0]    t_color;
    logic           r_out_valid, r_sk_valid;
    logic [11:0]    r_out_col, r_out_row, r_sk_col, r_sk_row;
    logic [23:0]    r_out_color, r_sk_color;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_screen_height <= SCREEN_HEIGHT_RST;
            r_sky_rgb       <= '0;
            r_ground_rgb    <= '0;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_SCREEN_HEIGHT: r_screen_height <= pwdata[11:0];
                REG_SKY_RGB:       r_sky_rgb       <= pwdata[23:0];
                REG_GROUND_RGB:    r_ground_rgb    <= pwdata[23:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_SCREEN_HEIGHT: prdata = {20'd0, r_screen_height};
            REG_SKY_RGB:       prdata = {8'd0, r_sky_rgb};
            REG_GROUND_RGB:    prdata = {8'd0, r_ground_rgb};
            default:           prdata = 32'd0;
        endcase
    end

    assign en      = !r_sk_valid;
    assign o_ready = en;

    always_comb begin
        req.mode           = i_mode;
        req.screen_column  = i_screen_column;
        req.screen_row     = i_screen_row;
        req.wall_top       = i_wall_top;
        req.wall_bottom    = i_wall_bottom;
        req.wall_height    = i_wall_height;
        req.hit_fraction   = i_hit_fraction;
        req.hit_side       = i_hit_side;
        req.ray_x_positive = i_ray_x_positive;
        req.ray_y_negative = i_ray_y_negative;
        req.texel_index    = i_texel_index;
        req.texel_value    = i_texel_value;
    end

    tws_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_en            (en),
        .i_vld           (i_valid),
        .i_req           (req),
        .i_screen_height (r_screen_height),
        .i_sky_rgb       (r_sky_rgb),
        .i_ground_rgb    (r_ground_rgb),
        .o_vld           (f_vld),
        .o_pay           (f_pay),
        .o_p             (f_p),
        .o_d             (f_d)
    );

    tws_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (f_vld),
        .i_pay   (f_pay),
        .i_p     (f_p),
        .i_d     (f_d),
        .o_vld   (d_vld),
        .o_pay   (d_pay),
        .o_q     (d_q)
    );

    tws_tex u_tex (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (d_vld),
        .i_pay   (d_pay),
        .i_q     (d_q),
        .o_vld   (t_vld),
        .o_col   (t_col),
        .o_row   (t_row),
        .o_color (t_color)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_sk_valid  <= 1'b0;
        end else if (r_sk_valid) begin
            if (i_ready) begin
                r_out_valid <= 1'b1;
                r_sk_valid  <= 1'b0;
            end
        end else if (!r_out_valid || i_ready) begin
            r_out_valid <= t_vld;
        end else if (t_vld) begin
            r_sk_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_sk_valid) begin
            if (i_ready) begin
                r_out_col   <= r_sk_col;
                r_out_row   <= r_sk_row;
                r_out_color <= r_sk_color;
            end
        end else if (!r_out_valid || i_ready) begin
            r_out_col   <= t_col;
            r_out_row   <= t_row;
            r_out_color <= t_color;
        end else begin
            r_sk_col   <= t_col;
            r_sk_row   <= t_row;
            r_sk_color <= t_color;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_pixel_column = r_out_col;
    assign o_pixel_row    = r_out_row;
    assign o_pixel_color  = r_out_color;

    assign out_stall = r_out_valid && !i_ready;

    `TWS_ASSERT_NOW(a_skid_behind_out, r_sk_valid, r_out_valid, "Skid full while output empty.")
    `TWS_ASSERT_NEXT(a_skid_fills, out_stall && !r_sk_valid && t_vld, r_sk_valid, "Skid missed a pixel.")
    `TWS_ASSERT_NOW(a_row_on_screen, o_valid, o_pixel_row < r_screen_height, "Row off screen.")
endmodule
`default_nettype wire
